### design/cwp_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and fixed-point helpers for the collider world pose unit.
// Used by every module of the block but cwp_ram; depends on nothing else.
package cwp_pkg;

  localparam int QUAT_BITS      = 30;
  localparam int WORDS_PER_BONE = 12;
  localparam int NUM_LANES      = 8;
  localparam int NUM_STAGES     = 8;
  localparam int IN_DATA_W      = 328;
  localparam int IN_USER_W      = 5;
  localparam int OUT_DATA_W     = 288;
  localparam int OUT_USER_W     = 2;
  localparam int CFG_ADDR_W     = 6;
  localparam int CFG_DATA_W     = 64;
  localparam logic [3:0] LAST_PRIM_KIND = 4'd5;

  typedef logic [31:0] word_t;
  typedef word_t [2:0] vec_t;
  typedef word_t [3:0] quat_t;
  typedef word_t [WORDS_PER_BONE-1:0] mat_t;
  typedef vec_t [NUM_LANES-1:0] corners_t;
  typedef logic signed [63-QUAT_BITS:0] qprod_t;

  typedef enum logic [1:0] {
    SHAPE_SPHERE  = 2'd0,
    SHAPE_CAPSULE = 2'd1,
    SHAPE_BOX     = 2'd2
  } shape_t;

  typedef enum logic [2:0] {
    REG_OWNER0        = 3'd0,
    REG_OWNER1        = 3'd1,
    REG_OWNER2        = 3'd2,
    REG_OWNER3        = 3'd3,
    REG_OWNER4        = 3'd4,
    REG_OWNER5        = 3'd5,
    REG_OWNER_PRESENT = 3'd6,
    REG_BONE_COUNT    = 3'd7
  } reg_idx_t;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_PRIM = 1'b1
  } op_t;

  typedef struct packed {
    logic [NUM_STAGES-1:0] en;
  } pipe_ctrl_t;

  function automatic word_t sat32(input logic signed [63:0] x);
    word_t r;
    if (x > 64'sd2147483647) begin
      r = 32'h7fff_ffff;
    end else if (x < -64'sd2147483648) begin
      r = 32'h8000_0000;
    end else begin
      r = x[31:0];
    end
    return r;
  endfunction

  function automatic word_t neg_sat(input word_t x);
    word_t r;
    if (x == 32'h8000_0000) begin
      r = 32'h7fff_ffff;
    end else begin
      r = 32'd0 - x;
    end
    return r;
  endfunction

  function automatic qprod_t qmul(input word_t q, input word_t v);
    logic signed [63:0] p;
    p = $signed(q) * $signed(v);
    return p[63:QUAT_BITS];
  endfunction

endpackage

### design/cwp_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered, enabled read port.
// Stands alone; no package needed.
module cwp_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### design/cwp_lane.sv
`timescale 1ns / 1ps
// One corner lane: quaternion rotation, offset add or subtract and affine transform over five stages.
// Depends on cwp_pkg.
module cwp_lane #(
  parameter int FRAC_BITS = 16,
  parameter int LANE      = 0
) (
  input  logic                clk,
  input  cwp_pkg::pipe_ctrl_t ctrl,
  input  cwp_pkg::shape_t     cls,
  input  cwp_pkg::vec_t       off,
  input  cwp_pkg::vec_t       size,
  input  cwp_pkg::quat_t      quat,
  input  cwp_pkg::mat_t       mat,
  input  cwp_pkg::vec_t       trans,
  output cwp_pkg::vec_t       pos
);
  import cwp_pkg::*;

  localparam int PW = 64 - FRAC_BITS;
  typedef logic signed [PW-1:0] fprod_t;

  vec_t   rel_c;
  logic   sub_c;
  qprod_t tp_c [6];
  vec_t   rel1, off1;
  quat_t  quat1;
  logic   sub1;
  qprod_t tp1 [6];

  vec_t   t_c;
  qprod_t rp_c [9];
  vec_t   rel2, off2;
  logic   sub2;
  qprod_t rp2 [9];

  vec_t   lc_c;
  vec_t   lc3;

  fprod_t fp_c [9];
  fprod_t fp4 [9];

  vec_t   pos_c;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      unique case (cls)
        SHAPE_SPHERE:  rel_c[a] = '0;
        SHAPE_CAPSULE: rel_c[a] = (a == 1) ? size[1] : '0;
        SHAPE_BOX:     rel_c[a] = (((LANE >> a) & 1) != 0) ? size[a] : neg_sat(size[a]);
        default:       rel_c[a] = '0;
      endcase
    end
    sub_c   = (cls == SHAPE_CAPSULE) && (LANE == 0);
    tp_c[0] = qmul(quat[1], rel_c[2]);
    tp_c[1] = qmul(quat[2], rel_c[1]);
    tp_c[2] = qmul(quat[2], rel_c[0]);
    tp_c[3] = qmul(quat[0], rel_c[2]);
    tp_c[4] = qmul(quat[0], rel_c[1]);
    tp_c[5] = qmul(quat[1], rel_c[0]);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[1]) begin
      rel1  <= rel_c;
      off1  <= off;
      quat1 <= quat;
      sub1  <= sub_c;
      tp1   <= tp_c;
    end
  end

  always_comb begin
    logic signed [63:0] d;
    for (int a = 0; a < 3; a++) begin
      d = tp1[2*a] - tp1[2*a+1];
      t_c[a] = sat32(d <<< 1);
    end
    rp_c[0] = qmul(quat1[3], t_c[0]);
    rp_c[1] = qmul(quat1[1], t_c[2]);
    rp_c[2] = qmul(quat1[2], t_c[1]);
    rp_c[3] = qmul(quat1[3], t_c[1]);
    rp_c[4] = qmul(quat1[2], t_c[0]);
    rp_c[5] = qmul(quat1[0], t_c[2]);
    rp_c[6] = qmul(quat1[3], t_c[2]);
    rp_c[7] = qmul(quat1[0], t_c[1]);
    rp_c[8] = qmul(quat1[1], t_c[0]);
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[2]) begin
      rel2 <= rel1;
      off2 <= off1;
      sub2 <= sub1;
      rp2  <= rp_c;
    end
  end

  always_comb begin
    logic signed [63:0] acc;
    logic signed [63:0] sum;
    word_t o;
    for (int a = 0; a < 3; a++) begin
      acc = $signed(rel2[a]) + rp2[3*a] + rp2[3*a+1] - rp2[3*a+2];
      o   = sat32(acc);
      if (sub2) begin
        sum = $signed(off2[a]) - $signed(o);
      end else begin
        sum = $signed(off2[a]) + $signed(o);
      end
      lc_c[a] = sat32(sum);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[3]) begin
      lc3 <= lc_c;
    end
  end

  always_comb begin
    logic signed [63:0] prod;
    for (int r = 0; r < 3; r++) begin
      for (int i = 0; i < 3; i++) begin
        prod = $signed(mat[3*i+r]) * $signed(lc3[i]);
        fp_c[3*r+i] = prod[63:FRAC_BITS];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[4]) begin
      fp4 <= fp_c;
    end
  end

  always_comb begin
    logic signed [63:0] acc;
    for (int r = 0; r < 3; r++) begin
      acc = fp4[3*r] + fp4[3*r+1] + fp4[3*r+2] + $signed(trans[r]);
      pos_c[r] = sat32(acc);
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[5]) begin
      pos <= pos_c;
    end
  end

endmodule

### design/cwp_aabb.sv
`timescale 1ns / 1ps
// Bounds reduction over the eight corner lanes and result formatting, two stages.
// Depends on cwp_pkg.
module cwp_aabb (
  input  logic                clk,
  input  cwp_pkg::pipe_ctrl_t ctrl,
  input  cwp_pkg::shape_t     cls,
  input  cwp_pkg::word_t      radius,
  input  cwp_pkg::corners_t   corners,
  output cwp_pkg::shape_t     res_kind,
  output cwp_pkg::vec_t       res_a,
  output cwp_pkg::vec_t       res_b,
  output cwp_pkg::vec_t       res_ext
);
  import cwp_pkg::*;

  vec_t   lo_c, hi_c;
  vec_t   lo6, hi6, p0_6, p1_6;
  shape_t cls6;
  word_t  rad6;
  vec_t   a_c, b_c, ext_c;

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      lo_c[a] = corners[0][a];
      hi_c[a] = corners[0][a];
      for (int c = 1; c < NUM_LANES; c++) begin
        if ($signed(corners[c][a]) < $signed(lo_c[a])) begin
          lo_c[a] = corners[c][a];
        end
        if ($signed(corners[c][a]) > $signed(hi_c[a])) begin
          hi_c[a] = corners[c][a];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[6]) begin
      lo6  <= lo_c;
      hi6  <= hi_c;
      p0_6 <= corners[0];
      p1_6 <= corners[1];
      cls6 <= cls;
      rad6 <= radius;
    end
  end

  always_comb begin
    logic signed [32:0] s;
    logic signed [32:0] d;
    a_c   = p0_6;
    b_c   = '0;
    ext_c = '0;
    unique case (cls6)
      SHAPE_SPHERE: begin
        ext_c[0] = rad6;
      end
      SHAPE_CAPSULE: begin
        b_c      = p1_6;
        ext_c[0] = rad6;
      end
      default: begin
        for (int a = 0; a < 3; a++) begin
          s = $signed(lo6[a]) + $signed(hi6[a]);
          d = $signed(hi6[a]) - $signed(lo6[a]);
          a_c[a]   = s[32:1];
          ext_c[a] = d[32:1];
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[7]) begin
      res_kind <= cls6;
      res_a    <= a_c;
      res_b    <= b_c;
      res_ext  <= ext_c;
    end
  end

endmodule

### design/collider_world_pose_unit.sv
`timescale 1ns / 1ps
// Throughput: one word per cycle while the master side takes results without backpressure;
// eight corner lanes work in parallel on every primitive.
// Loads write the bone store in the accept cycle and give no result; a primitive may follow
// in the next cycle. Each stage holds under backpressure and fills its own bubbles.
// Reset clears valid bits and configuration registers; the bone store is not cleared.
// Top level; depends on cwp_pkg, cwp_ram, cwp_lane and cwp_aabb.
module collider_world_pose_unit #(
  parameter int MAX_BONES = 64,
  parameter int FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // bone, off_x, off_y, off_z, size_x, size_y, size_z, rot_xy, rot_zw, zero pad
  input  logic [cwp_pkg::IN_DATA_W-1:0]     s_tdata,
  // op, kind
  input  logic [cwp_pkg::IN_USER_W-1:0]     s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // a_x, a_y, a_z, b_x, b_y, b_z, ext_x, ext_y, ext_z
  output logic [cwp_pkg::OUT_DATA_W-1:0]    m_tdata,
  // shape_kind
  output logic [cwp_pkg::OUT_USER_W-1:0]    m_tuser,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cwp_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [cwp_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [cwp_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready
);
  import cwp_pkg::*;

  localparam int AW = (MAX_BONES > 1) ? $clog2(MAX_BONES) : 1;
  localparam logic [10:0] MAX_BONES_W = 11'(MAX_BONES);
  localparam word_t FX_ONE = 32'd1 << FRAC_BITS;

  logic [63:0] owner [6];
  logic        owner_present;
  logic [6:0]  bone_count;
  reg_idx_t    reg_idx;
  logic        cfg_wr;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_t'(paddr[5:3]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      owner         <= '{default: '0};
      owner_present <= 1'b0;
      bone_count    <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_OWNER0:        owner[0] <= pwdata;
        REG_OWNER1:        owner[1] <= pwdata;
        REG_OWNER2:        owner[2] <= pwdata;
        REG_OWNER3:        owner[3] <= pwdata;
        REG_OWNER4:        owner[4] <= pwdata;
        REG_OWNER5:        owner[5] <= pwdata;
        REG_OWNER_PRESENT: owner_present <= pwdata[0];
        REG_BONE_COUNT:    bone_count <= pwdata[6:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_OWNER0:        prdata = owner[0];
      REG_OWNER1:        prdata = owner[1];
      REG_OWNER2:        prdata = owner[2];
      REG_OWNER3:        prdata = owner[3];
      REG_OWNER4:        prdata = owner[4];
      REG_OWNER5:        prdata = owner[5];
      REG_OWNER_PRESENT: prdata = {63'd0, owner_present};
      REG_BONE_COUNT:    prdata = {57'd0, bone_count};
    endcase
  end

  // Input word fields.
  op_t        in_op;
  logic [3:0] in_kind;
  logic [6:0] in_bone;
  vec_t       in_off, in_size;
  quat_t      in_quat;

  assign in_op      = op_t'(s_tuser[0]);
  assign in_kind    = s_tuser[4:1];
  assign in_bone    = s_tdata[6:0];
  assign in_off[0]  = s_tdata[38:7];
  assign in_off[1]  = s_tdata[70:39];
  assign in_off[2]  = s_tdata[102:71];
  assign in_size[0] = s_tdata[134:103];
  assign in_size[1] = s_tdata[166:135];
  assign in_size[2] = s_tdata[198:167];
  assign in_quat[0] = s_tdata[230:199];
  assign in_quat[1] = s_tdata[262:231];
  assign in_quat[2] = s_tdata[294:263];
  assign in_quat[3] = s_tdata[326:295];

  // Pipeline control: a stage advances when it is empty or its successor advances.
  logic [NUM_STAGES-1:0] vld;
  pipe_ctrl_t            ctrl;
  logic                  accept;

  always_comb begin
    ctrl.en[NUM_STAGES-1] = !vld[NUM_STAGES-1] || m_tready;
    for (int i = NUM_STAGES - 2; i >= 0; i--) begin
      ctrl.en[i] = !vld[i] || ctrl.en[i+1];
    end
  end

  assign s_tready = ctrl.en[0];
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = vld[NUM_STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (ctrl.en[0]) begin
        vld[0] <= accept && (in_op == OP_PRIM) && (in_kind <= LAST_PRIM_KIND);
      end
      for (int i = 1; i < NUM_STAGES; i++) begin
        if (ctrl.en[i]) begin
          vld[i] <= vld[i-1];
        end
      end
    end
  end

  // Bone store: one RAM per matrix word, all read together.
  logic          load_ok;
  logic [AW-1:0] bone_addr;
  word_t         ram_rdata [WORDS_PER_BONE];

  assign load_ok   = accept && (in_op == OP_LOAD) && !in_bone[6] &&
                     (11'(in_bone[5:0]) < MAX_BONES_W) && (in_kind < 4'(WORDS_PER_BONE));
  assign bone_addr = AW'(in_bone[5:0]);

  for (genvar k = 0; k < WORDS_PER_BONE; k++) begin : g_store
    cwp_ram #(
      .WIDTH(32),
      .DEPTH(MAX_BONES),
      .AW   (AW)
    ) u_ram (
      .clk  (clk),
      .we   (load_ok && (in_kind == 4'(k))),
      .waddr(bone_addr),
      .wdata(in_off[0]),
      .re   (ctrl.en[0]),
      .raddr(bone_addr),
      .rdata(ram_rdata[k])
    );
  end

  // Stage 0: registered input fields.
  logic [10:0] limit;
  shape_t      cls_c;
  shape_t      cls0, cls1, cls2, cls3, cls4, cls5;
  logic        hit0;
  vec_t        off0, size0;
  quat_t       quat0;
  word_t       rad1, rad2, rad3, rad4, rad5;

  assign limit = (11'(bone_count) < MAX_BONES_W) ? 11'(bone_count) : MAX_BONES_W;

  always_comb begin
    priority case (1'b1)
      (in_kind == 4'd0): cls_c = SHAPE_SPHERE;
      (in_kind == 4'd1): cls_c = SHAPE_CAPSULE;
      default:           cls_c = SHAPE_BOX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[0]) begin
      cls0  <= cls_c;
      hit0  <= !in_bone[6] && (11'(in_bone[5:0]) < limit);
      off0  <= in_off;
      size0 <= in_size;
      quat0 <= in_quat;
    end
  end

  // Stage 1 to 4: world matrix selection and its travel beside the lanes.
  mat_t m_c, m1, m2, m3;
  vec_t trans4;

  always_comb begin
    for (int k = 0; k < WORDS_PER_BONE; k++) begin
      if (hit0) begin
        m_c[k] = ram_rdata[k];
      end else if (owner_present) begin
        m_c[k] = (k % 2 == 1) ? owner[k/2][63:32] : owner[k/2][31:0];
      end else begin
        m_c[k] = (k == 0 || k == 4 || k == 8) ? FX_ONE : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.en[1]) begin
      m1   <= m_c;
      cls1 <= cls0;
      rad1 <= size0[0];
    end
    if (ctrl.en[2]) begin
      m2   <= m1;
      cls2 <= cls1;
      rad2 <= rad1;
    end
    if (ctrl.en[3]) begin
      m3   <= m2;
      cls3 <= cls2;
      rad3 <= rad2;
    end
    if (ctrl.en[4]) begin
      trans4 <= {m3[11], m3[10], m3[9]};
      cls4   <= cls3;
      rad4   <= rad3;
    end
    if (ctrl.en[5]) begin
      cls5 <= cls4;
      rad5 <= rad4;
    end
  end

  corners_t corners;

  for (genvar c = 0; c < NUM_LANES; c++) begin : g_lane
    cwp_lane #(
      .FRAC_BITS(FRAC_BITS),
      .LANE     (c)
    ) u_lane (
      .clk  (clk),
      .ctrl (ctrl),
      .cls  (cls0),
      .off  (off0),
      .size (size0),
      .quat (quat0),
      .mat  (m3),
      .trans(trans4),
      .pos  (corners[c])
    );
  end

  shape_t res_kind;
  vec_t   res_a, res_b, res_ext;

  cwp_aabb u_aabb (
    .clk     (clk),
    .ctrl    (ctrl),
    .cls     (cls5),
    .radius  (rad5),
    .corners (corners),
    .res_kind(res_kind),
    .res_a   (res_a),
    .res_b   (res_b),
    .res_ext (res_ext)
  );

  assign m_tuser = res_kind;
  assign m_tdata = {res_ext[2], res_ext[1], res_ext[0],
                    res_b[2], res_b[1], res_b[0],
                    res_a[2], res_a[1], res_a[0]};

  // A stalled input side always traces back to a result waiting at the output.
  a_stall_from_output: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (m_tvalid && !m_tready))
    else $error("input stalled without output backpressure");

  // Loads never enter the pipeline.
  a_load_no_result: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_op == OP_LOAD)) |=> !vld[0])
    else $error("load word entered the pipeline");

  // Only boxes carry extents beyond the radius.
  a_ext_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && (res_kind != SHAPE_BOX)) |-> (res_ext[1] == '0 && res_ext[2] == '0))
    else $error("nonzero extent on a sphere or capsule");

  // A bone match requires a nonzero bone count.
  a_hit_needs_count: assert property (@(posedge clk) disable iff (rst)
    (vld[0] && hit0) |-> (bone_count != '0))
    else $error("bone matrix used with no bones configured");

endmodule
